// File: sv/bhc_pkg.sv
// Package for the barometric and humidity compensation block.
// Holds the transaction types, register indexes and 32-bit wrap helpers.
// No dependencies.
package bhc_pkg;

    localparam int unsigned DivBits = 32;
    localparam int unsigned AddrBits = 6;
    localparam logic [19:0] Skip20 = 20'h80000;
    localparam logic [15:0] Skip16 = 16'h8000;

    typedef enum logic [2:0] {
        RegCalTemp      = 3'd0,
        RegCalPressLow  = 3'd1,
        RegCalPressMid  = 3'd2,
        RegCalPressHigh = 3'd3,
        RegCalHumMain   = 3'd4,
        RegCalHumPair   = 3'd5,
        RegHumPresent   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] temp_centi;
        logic               temp_valid;
        logic [19:0]        press_pa;
        logic               press_valid;
        logic [16:0]        hum_q10;
        logic               hum_valid;
    } result_t;

    typedef struct packed {
        logic [15:0] temp_centi;
        logic        temp_valid;
        logic        press_valid;
        logic        big;
        logic        hum_valid;
        logic [31:0] hum_x1;
    } side_t;

    function automatic logic [31:0] mulw(input logic [31:0] x, input logic [31:0] y);
        logic [63:0] prod;
        prod = {32'b0, x} * {32'b0, y};
        return prod[31:0];
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx12(input logic [11:0] x);
        return {{20{x[11]}}, x};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

endpackage

// File: sv/bhc_div.sv
// Pipelined unsigned 32-bit divider, one quotient bit per stage.
// Carries a sideband record alongside each transaction. Uses bhc_pkg.
module bhc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       num,
    input  logic [31:0]       den,
    input  bhc_pkg::side_t    side_in,
    output logic              out_valid,
    output logic [31:0]       quo,
    output bhc_pkg::side_t    side_out
);

    logic           vld_reg  [1:bhc_pkg::DivBits];
    logic [31:0]    rem_reg  [1:bhc_pkg::DivBits];
    logic [31:0]    quo_reg  [1:bhc_pkg::DivBits];
    logic [31:0]    num_reg  [1:bhc_pkg::DivBits];
    logic [31:0]    den_reg  [1:bhc_pkg::DivBits];
    bhc_pkg::side_t side_reg [1:bhc_pkg::DivBits];

    for (genvar k = 0; k < bhc_pkg::DivBits; k++)
    begin : g_stage
        logic           src_vld;
        logic [31:0]    src_rem;
        logic [31:0]    src_quo;
        logic [31:0]    src_num;
        logic [31:0]    src_den;
        bhc_pkg::side_t src_side;
        logic [32:0]    trial;
        logic [32:0]    diff;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign src_vld  = in_valid;
            assign src_rem  = '0;
            assign src_quo  = '0;
            assign src_num  = num;
            assign src_den  = den;
            assign src_side = side_in;
        end
        else
        begin : g_next
            assign src_vld  = vld_reg[k];
            assign src_rem  = rem_reg[k];
            assign src_quo  = quo_reg[k];
            assign src_num  = num_reg[k];
            assign src_den  = den_reg[k];
            assign src_side = side_reg[k];
        end

        assign trial = {src_rem, src_num[31]};
        assign diff  = trial - {1'b0, src_den};
        assign ge    = (trial >= {1'b0, src_den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? diff[31:0] : trial[31:0];
                quo_reg[k+1]  <= {src_quo[30:0], ge};
                num_reg[k+1]  <= {src_num[30:0], 1'b0};
                den_reg[k+1]  <= src_den;
                side_reg[k+1] <= src_side;
            end
        end
    end

    assign out_valid = vld_reg[bhc_pkg::DivBits];
    assign quo       = quo_reg[bhc_pkg::DivBits];
    assign side_out  = side_reg[bhc_pkg::DivBits];

endmodule

// File: sv/baro_humidity_compensation.sv
// Top level of the barometric and humidity compensation block.
// Depends on bhc_pkg and bhc_div.
//
// The block takes one raw sample transaction per clock while not stalled and returns one result
// transaction through seven arithmetic stages, a 32-stage divider for
// the pressure quotient and three stages of final correction. The whole pipeline
// moves forward whenever the output register is empty or being taken, so the
// sustained rate is one transaction per cycle. Calibration registers are written
// through the APB port at byte address 8*index and are read back the same way.
module baro_humidity_compensation (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bhc_pkg::AddrBits-1:0]    paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  bhc_pkg::sample_t                sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output bhc_pkg::result_t                result
);

    logic [47:0] cal_temp_reg;
    logic [47:0] cal_press_low_reg;
    logic [47:0] cal_press_mid_reg;
    logic [47:0] cal_press_high_reg;
    logic [39:0] cal_hum_main_reg;
    logic [23:0] cal_hum_pair_reg;
    logic        hum_present_reg;
    bhc_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign idx    = bhc_pkg::reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg       <= '0;
            cal_press_low_reg  <= '0;
            cal_press_mid_reg  <= '0;
            cal_press_high_reg <= '0;
            cal_hum_main_reg   <= '0;
            cal_hum_pair_reg   <= '0;
            hum_present_reg    <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                bhc_pkg::RegCalTemp:      cal_temp_reg       <= pwdata[47:0];
                bhc_pkg::RegCalPressLow:  cal_press_low_reg  <= pwdata[47:0];
                bhc_pkg::RegCalPressMid:  cal_press_mid_reg  <= pwdata[47:0];
                bhc_pkg::RegCalPressHigh: cal_press_high_reg <= pwdata[47:0];
                bhc_pkg::RegCalHumMain:   cal_hum_main_reg   <= pwdata[39:0];
                bhc_pkg::RegCalHumPair:   cal_hum_pair_reg   <= pwdata[23:0];
                bhc_pkg::RegHumPresent:   hum_present_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            bhc_pkg::RegCalTemp:      prdata = {16'b0, cal_temp_reg};
            bhc_pkg::RegCalPressLow:  prdata = {16'b0, cal_press_low_reg};
            bhc_pkg::RegCalPressMid:  prdata = {16'b0, cal_press_mid_reg};
            bhc_pkg::RegCalPressHigh: prdata = {16'b0, cal_press_high_reg};
            bhc_pkg::RegCalHumMain:   prdata = {24'b0, cal_hum_main_reg};
            bhc_pkg::RegCalHumPair:   prdata = {40'b0, cal_hum_pair_reg};
            bhc_pkg::RegHumPresent:   prdata = {63'b0, hum_present_reg};
            default:                  prdata = '0;
        endcase
    end

    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
    logic [7:0]  h1, h3, h6;
    logic [11:0] h4, h5;

    assign t1 = cal_temp_reg[15:0];
    assign t2 = cal_temp_reg[31:16];
    assign t3 = cal_temp_reg[47:32];
    assign p1 = cal_press_low_reg[15:0];
    assign p2 = cal_press_low_reg[31:16];
    assign p3 = cal_press_low_reg[47:32];
    assign p4 = cal_press_mid_reg[15:0];
    assign p5 = cal_press_mid_reg[31:16];
    assign p6 = cal_press_mid_reg[47:32];
    assign p7 = cal_press_high_reg[15:0];
    assign p8 = cal_press_high_reg[31:16];
    assign p9 = cal_press_high_reg[47:32];
    assign h1 = cal_hum_main_reg[7:0];
    assign h2 = cal_hum_main_reg[23:8];
    assign h3 = cal_hum_main_reg[31:24];
    assign h6 = cal_hum_main_reg[39:32];
    assign h4 = cal_hum_pair_reg[11:0];
    assign h5 = cal_hum_pair_reg[23:12];

    logic adv;

    assign adv          = !result_valid || !result_stall;
    assign sample_stall = !adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, vd1_reg, vd2_reg;
    logic div_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            vd1_reg      <= 1'b0;
            vd2_reg      <= 1'b0;
            result_valid <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg       <= sample_valid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            v5_reg       <= v4_reg;
            v6_reg       <= v5_reg;
            v7_reg       <= v6_reg;
            vd1_reg      <= div_valid;
            vd2_reg      <= vd1_reg;
            result_valid <= vd2_reg;
        end
    end

    // Fine temperature.
    logic [31:0] a0, b0;
    logic [31:0] ta1_reg, bb1_reg, ta2_reg, tb2_reg, tf3_reg;
    logic [19:0] ut1_reg, up1_reg, up2_reg, up3_reg, up4_reg, up5_reg, up6_reg;
    logic [15:0] uh1_reg, uh2_reg, uh3_reg, uh4_reg;
    logic        ut2_skip_reg, ut3_skip_reg;

    assign a0 = {15'b0, sample.raw_temp[19:3]} - {15'b0, t1, 1'b0};
    assign b0 = {16'b0, sample.raw_temp[19:4]} - {16'b0, t1};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ta1_reg      <= bhc_pkg::mulw(a0, bhc_pkg::sx16(t2));
            bb1_reg      <= bhc_pkg::mulw(b0, b0);
            ut1_reg      <= sample.raw_temp;
            up1_reg      <= sample.raw_press;
            uh1_reg      <= sample.raw_hum;
            ta2_reg      <= bhc_pkg::sra(ta1_reg, 11);
            tb2_reg      <= bhc_pkg::mulw(bhc_pkg::sra(bb1_reg, 12), bhc_pkg::sx16(t3));
            ut2_skip_reg <= (ut1_reg == bhc_pkg::Skip20);
            up2_reg      <= up1_reg;
            uh2_reg      <= uh1_reg;
            tf3_reg      <= ta2_reg + bhc_pkg::sra(tb2_reg, 14);
            ut3_skip_reg <= ut2_skip_reg;
            up3_reg      <= up2_reg;
            uh3_reg      <= uh2_reg;
        end
    end

    // Stage 4: temperature result and first pressure and humidity products.
    logic [31:0] t5, tsh, pa, pq, hx1;
    logic [15:0] tsat;

    assign t5  = tf3_reg + {tf3_reg[29:0], 2'b00} + 32'd128;
    assign tsh = bhc_pkg::sra(t5, 8);
    assign pa  = bhc_pkg::sra(tf3_reg, 1) - 32'd64000;
    assign pq  = bhc_pkg::sra(pa, 2);
    assign hx1 = tf3_reg - 32'd76800;

    always_comb
    begin
        priority if ($signed(tsh) > 32'sd32767)
        begin
            tsat = 16'h7FFF;
        end
        else if ($signed(tsh) < -32'sd32768)
        begin
            tsat = 16'h8000;
        end
        else
        begin
            tsat = tsh[15:0];
        end
    end

    logic [15:0] tc4_reg, tc5_reg, tc6_reg;
    logic        tv4_reg, tv5_reg, tv6_reg;
    logic [31:0] sq4_reg, m5_4_reg, m2_4_reg, hx5_4_reg, h6_4_reg, h3_4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tc4_reg   <= ut3_skip_reg ? 16'h0000 : tsat;
            tv4_reg   <= !ut3_skip_reg;
            sq4_reg   <= bhc_pkg::mulw(pq, pq);
            m5_4_reg  <= bhc_pkg::mulw(pa, bhc_pkg::sx16(p5));
            m2_4_reg  <= bhc_pkg::mulw(bhc_pkg::sx16(p2), pa);
            hx5_4_reg <= bhc_pkg::mulw(bhc_pkg::sx12(h5), hx1);
            h6_4_reg  <= bhc_pkg::mulw(hx1, bhc_pkg::sx8(h6));
            h3_4_reg  <= bhc_pkg::mulw(hx1, {24'b0, h3});
            up4_reg   <= up3_reg;
            uh4_reg   <= uh3_reg;
        end
    end

    // Stage 5.
    logic [31:0] x2raw;
    logic [31:0] b5_reg, m3_5_reg, m5_5_reg, m2_5_reg, x3a5_reg, x2_5_reg;
    logic        hv5_reg, hv6_reg;

    assign x2raw = ({2'b0, uh4_reg, 14'b0} - {h4, 20'b0}) - hx5_4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tc5_reg  <= tc4_reg;
            tv5_reg  <= tv4_reg;
            b5_reg   <= bhc_pkg::mulw(bhc_pkg::sra(sq4_reg, 11), bhc_pkg::sx16(p6));
            m3_5_reg <= bhc_pkg::mulw(bhc_pkg::sx16(p3), bhc_pkg::sra(sq4_reg, 13));
            m5_5_reg <= m5_4_reg;
            m2_5_reg <= m2_4_reg;
            x3a5_reg <= bhc_pkg::mulw(bhc_pkg::sra(h6_4_reg, 10),
                                      bhc_pkg::sra(h3_4_reg, 11) + 32'd32768);
            x2_5_reg <= bhc_pkg::sra(x2raw + 32'd16384, 15);
            hv5_reg  <= hum_present_reg && (uh4_reg != bhc_pkg::Skip16);
            up5_reg  <= up4_reg;
        end
    end

    // Stage 6.
    logic [31:0] b6sum, a6sum;
    logic [31:0] b6_reg, a6_reg, x3_6_reg, x2_6_reg;

    assign b6sum = b5_reg + {m5_5_reg[30:0], 1'b0};
    assign a6sum = bhc_pkg::sra(bhc_pkg::sra(m3_5_reg, 3) + bhc_pkg::sra(m2_5_reg, 1), 18);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tc6_reg  <= tc5_reg;
            tv6_reg  <= tv5_reg;
            b6_reg   <= bhc_pkg::sra(b6sum, 2) + {p4, 16'b0};
            a6_reg   <= bhc_pkg::mulw(a6sum + 32'd32768, {16'b0, p1});
            x3_6_reg <= bhc_pkg::mulw(bhc_pkg::sra(x3a5_reg, 10) + 32'd2097152,
                                      bhc_pkg::sx16(h2)) + 32'd8192;
            x2_6_reg <= x2_5_reg;
            hv6_reg  <= hv5_reg;
            up6_reg  <= up5_reg;
        end
    end

    // Stage 7: divisor and scaled numerator.
    logic [31:0] dv, praw;
    logic [31:0] p7_reg, d7_reg;
    bhc_pkg::side_t side7_reg;

    assign dv   = bhc_pkg::sra(a6_reg, 15);
    assign praw = (32'd1048576 - {12'b0, up6_reg}) - bhc_pkg::sra(b6_reg, 12);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p7_reg                <= bhc_pkg::mulw(praw, 32'd3125);
            d7_reg                <= dv;
            side7_reg.temp_centi  <= tc6_reg;
            side7_reg.temp_valid  <= tv6_reg;
            side7_reg.press_valid <= (up6_reg != bhc_pkg::Skip20) && (dv != 32'd0);
            side7_reg.big         <= 1'b0;
            side7_reg.hum_valid   <= hv6_reg;
            side7_reg.hum_x1      <= bhc_pkg::mulw(x2_6_reg, bhc_pkg::sra(x3_6_reg, 14));
        end
    end

    bhc_pkg::side_t side_div_in, side_div;
    logic [31:0]    div_num, div_quo;

    always_comb
    begin
        side_div_in     = side7_reg;
        side_div_in.big = p7_reg[31];
    end

    assign div_num = p7_reg[31] ? p7_reg : {p7_reg[30:0], 1'b0};

    bhc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (v7_reg),
        .num      (div_num),
        .den      (d7_reg),
        .side_in  (side_div_in),
        .out_valid(div_valid),
        .quo      (div_quo),
        .side_out (side_div)
    );

    // Final correction.
    logic [31:0] pdiv, rd;
    logic [31:0] p_d1_reg, pp_d1_reg, e_d1_reg, rr_d1_reg;
    logic [31:0] p_d2_reg, e_d2_reg, c_d2_reg, hh_d2_reg;
    bhc_pkg::side_t side_d1_reg, side_d2_reg;

    assign pdiv = side_div.big ? {div_quo[30:0], 1'b0} : div_quo;
    assign rd   = bhc_pkg::sra(side_div.hum_x1, 15);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_d1_reg    <= pdiv;
            pp_d1_reg   <= bhc_pkg::mulw({3'b0, pdiv[31:3]}, {3'b0, pdiv[31:3]});
            e_d1_reg    <= bhc_pkg::sra(bhc_pkg::mulw({2'b0, pdiv[31:2]},
                                                      bhc_pkg::sx16(p8)), 13);
            rr_d1_reg   <= bhc_pkg::mulw(rd, rd);
            side_d1_reg <= side_div;
            p_d2_reg    <= p_d1_reg;
            e_d2_reg    <= e_d1_reg;
            c_d2_reg    <= bhc_pkg::sra(bhc_pkg::mulw(bhc_pkg::sx16(p9),
                                                      {13'b0, pp_d1_reg[31:13]}), 12);
            hh_d2_reg   <= bhc_pkg::mulw(bhc_pkg::sra(rr_d1_reg, 7), {24'b0, h1});
            side_d2_reg <= side_d1_reg;
        end
    end

    logic [31:0] pfin, hx;
    logic [19:0] psat;
    logic [16:0] hq;

    assign pfin = p_d2_reg + bhc_pkg::sra(c_d2_reg + e_d2_reg + bhc_pkg::sx16(p7), 4);
    assign psat = (pfin[31:20] != 12'd0) ? 20'hFFFFF : pfin[19:0];
    assign hx   = side_d2_reg.hum_x1 - bhc_pkg::sra(hh_d2_reg, 4);

    always_comb
    begin
        priority if ($signed(hx) < 32'sd0)
        begin
            hq = '0;
        end
        else if ($signed(hx) > 32'sd419430400)
        begin
            hq = 17'd102400;
        end
        else
        begin
            hq = hx[28:12];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result.temp_centi  <= side_d2_reg.temp_centi;
            result.temp_valid  <= side_d2_reg.temp_valid;
            result.press_pa    <= side_d2_reg.press_valid ? psat : 20'd0;
            result.press_valid <= side_d2_reg.press_valid;
            result.hum_q10     <= side_d2_reg.hum_valid ? hq : 17'd0;
            result.hum_valid   <= side_d2_reg.hum_valid;
        end
    end

endmodule

// File: sv/bhc_check.sv
// Port-level checker for baro_humidity_compensation, with its bind statement.
// Depends on bhc_pkg.
module bhc_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bhc_pkg::AddrBits-1:0]    paddr,
    input  logic [63:0]                     pwdata,
    input  logic [63:0]                     prdata,
    input  logic                            pready,
    input  logic                            sample_valid,
    input  logic                            sample_stall,
    input  bhc_pkg::sample_t                sample,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  bhc_pkg::result_t                result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("Stalled result transaction changed.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
        else $error("Input stalled while output was free.");

    a_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.temp_valid |-> result.temp_centi == 16'sd0)
        else $error("Invalid temperature is not zero.");

    a_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.press_valid |-> result.press_pa == 20'd0)
        else $error("Invalid pressure is not zero.");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.hum_q10 <= 17'd102400 &&
                         (result.hum_valid || result.hum_q10 == 17'd0))
        else $error("Humidity out of range.");

endmodule

bind baro_humidity_compensation bhc_check u_bhc_check (.*);
